>>> rtl/core/per_hop_latency_stats_table_unit_defines.svh
// Assertion macros used by the checker file of the latency statistics table.
`ifndef PER_HOP_LATENCY_STATS_TABLE_UNIT_DEFINES_SVH
`define PER_HOP_LATENCY_STATS_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PHLST_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PHLST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/phlst_pkg.sv
// Shared constants for the per-hop latency statistics table.
`default_nettype none
package phlst_pkg;
  localparam int RTT_W      = 24;
  localparam int CNT_W      = 16;
  localparam int LOSS_W     = 14;
  localparam int WLEN_W     = 5;
  localparam int HOP_W      = 6;
  localparam int DIV_N_W    = 30;
  localparam int DIV_D_W    = 16;
  localparam int SUM_W      = 29;
  localparam int COUNT_MAX  = 65535;
  localparam int LOSS_SCALE = 10000;
  localparam int WLEN_RESET = 10;
endpackage
`default_nettype wire

>>> rtl/core/phlst_div.sv
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none
module phlst_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [phlst_pkg::DIV_N_W-1:0] num_i,
  input  wire [phlst_pkg::DIV_D_W-1:0] den_i,
  output logic                         done_o,
  output logic [phlst_pkg::DIV_N_W-1:0] quot_o
);
  import phlst_pkg::*;

  localparam int CW = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] num_q, num_d;
  logic [DIV_D_W-1:0] den_q;
  logic [DIV_D_W-1:0] rem_q, rem_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DIV_D_W:0]   trial;

  // One shift-and-subtract step.
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    trial  = {rem_q, num_q[DIV_N_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CW'(DIV_N_W);
      rem_d  = '0;
      num_d  = num_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DIV_D_W'(trial - {1'b0, den_q});
        num_d = {num_q[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_D_W-1:0];
        num_d = {num_q[DIV_N_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers need no reset.
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;
endmodule
`default_nettype wire

>>> rtl/core/per_hop_latency_stats_table_unit.sv
// Top level of the per-hop latency statistics table.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_wdata_i    | in
//  in      | in_valid_i, in_stall_o, hop/rtt/lost     | in
//  out     | out_valid_o, out_stall_i, min/max/avg... | out
//
// An item passes, from its acceptance, through one record update, n reads of the window
// memory on its single read port, n being the number of averaged times, the settling of
// the last read, and the two bit-serial dividers running side by side; an item with an
// out-of-range hop goes straight to the output. The result is then loaded into the output
// register, and only after that is the next item taken.
// Reset clears the used marks at once; no clearing pass is needed.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
module per_hop_latency_stats_table_unit #(
  parameter int HOPS   = 64,
  parameter int WINDOW = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [phlst_pkg::WLEN_W-1:0]  cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [phlst_pkg::HOP_W-1:0]   hop_i,
  input  wire [phlst_pkg::RTT_W-1:0]   rtt_us_i,
  input  wire                          lost_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [phlst_pkg::RTT_W-1:0]  min_us_o,
  output logic [phlst_pkg::RTT_W-1:0]  max_us_o,
  output logic [phlst_pkg::RTT_W-1:0]  avg_us_o,
  output logic [phlst_pkg::LOSS_W-1:0] loss_centipct_o,
  output logic                         stats_valid_o
);
  import phlst_pkg::*;

  localparam int HW   = (HOPS > 1) ? $clog2(HOPS) : 1;
  localparam int SW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int AW   = (HOPS * WINDOW > 1) ? $clog2(HOPS * WINDOW) : 1;
  localparam int WCAP = (WINDOW > 31) ? 31 : WINDOW;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_UPD  = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [RTT_W-1:0] min_t;
    logic [RTT_W-1:0] max_t;
    logic [SW-1:0]    slot;
    logic [CNT_W-1:0] tot;
    logic [CNT_W-1:0] rec;
  } rec_t;

  state_e state_q, state_d;

  logic [WLEN_W-1:0] wlen_q;
  logic [HOPS-1:0]   used_q;

  // Captured item.
  logic [HOP_W-1:0]  hop_q;
  logic [RTT_W-1:0]  rtt_q;
  logic              lost_q;
  logic              bad_q;

  // Memories.
  rec_t              rec_mem [HOPS];
  logic [RTT_W-1:0]  win_mem [HOPS*WINDOW];
  rec_t              rec_rd_q;
  logic [RTT_W-1:0]  win_rd_q;

  // Working registers.
  rec_t              new_q;
  logic [SW-1:0]     pos_q;
  logic [WLEN_W-1:0] cnt_q;
  logic [WLEN_W-1:0] n_q;
  logic              rd_pend_q;
  logic [SUM_W-1:0]  sum_q;
  logic [DIV_N_W-1:0] loss_num_q;
  logic              div_start_q;

  // Output register.
  logic              out_valid_q;
  logic [RTT_W-1:0]  min_q, max_q, avg_q;
  logic [LOSS_W-1:0] loss_q;
  logic              sv_q;

  logic              accept;
  logic              in_range;
  logic [HW-1:0]     hop_idx;
  rec_t              old_rec, upd_rec;
  logic [WLEN_W-1:0] eff_len;
  logic [CNT_W-1:0]  n_wide;
  logic [SW-1:0]     pos_prev;
  logic              win_re;
  logic [AW-1:0]     win_raddr, win_waddr;
  logic              load_out;
  logic              avg_done, loss_done;
  logic [DIV_N_W-1:0] avg_quot, loss_quot;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_range    = (int'(hop_i) < HOPS);
  assign hop_idx     = HW'(hop_q);

  // Window length clamped to one through the ring depth, and to at most 31.
  always_comb begin
    if (wlen_q == '0) begin
      eff_len = WLEN_W'(1);
    end else if (int'(wlen_q) > WCAP) begin
      eff_len = WLEN_W'(WCAP);
    end else begin
      eff_len = wlen_q;
    end
  end

  // Record update for the captured item.
  always_comb begin
    old_rec = rec_rd_q;
    if (!used_q[hop_idx]) begin
      old_rec.tot  = '0;
      old_rec.rec  = '0;
      old_rec.slot = '0;
    end
    upd_rec = old_rec;
    if (int'(old_rec.tot) < COUNT_MAX) begin
      upd_rec.tot = old_rec.tot + CNT_W'(1);
      if (!lost_q) begin
        upd_rec.rec = old_rec.rec + CNT_W'(1);
      end
    end else if (!lost_q && (old_rec.rec < old_rec.tot)) begin
      upd_rec.rec = old_rec.rec + CNT_W'(1);
    end
    if (!lost_q) begin
      if (upd_rec.rec == CNT_W'(1)) begin
        upd_rec.min_t = rtt_q;
        upd_rec.max_t = rtt_q;
      end else begin
        if (rtt_q < old_rec.min_t) upd_rec.min_t = rtt_q;
        if (rtt_q > old_rec.max_t) upd_rec.max_t = rtt_q;
      end
      if (int'(old_rec.slot) == WINDOW - 1) begin
        upd_rec.slot = '0;
      end else begin
        upd_rec.slot = old_rec.slot + SW'(1);
      end
    end
    if (upd_rec.rec < CNT_W'(eff_len)) begin
      n_wide = upd_rec.rec;
    end else begin
      n_wide = CNT_W'(eff_len);
    end
  end

  // Ring walk toward older entries.
  always_comb begin
    if (pos_q == '0) begin
      pos_prev = SW'(WINDOW - 1);
    end else begin
      pos_prev = pos_q - SW'(1);
    end
    win_re    = (state_q == ST_SUM) && (cnt_q != '0);
    win_raddr = AW'(hop_idx) * AW'(WINDOW) + AW'(pos_prev);
    win_waddr = AW'(hop_idx) * AW'(WINDOW) + AW'(old_rec.slot);
  end

  assign load_out = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = in_range ? ST_UPD : ST_FIN;
      end
      ST_UPD: state_d = ST_SUM;
      ST_SUM: begin
        if (cnt_q == '0 && !rd_pend_q) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!div_start_q && avg_done && loss_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wlen_q      <= WLEN_W'(WLEN_RESET);
      used_q      <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      div_start_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) wlen_q <= cfg_wdata_i;
      if (state_q == ST_UPD) used_q[hop_idx] <= 1'b1;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      rd_pend_q   <= win_re;
      div_start_q <= (state_q == ST_SUM) && (state_d == ST_DIV);
      if (state_q == ST_UPD) begin
        cnt_q <= n_wide[WLEN_W-1:0];
      end else if (win_re) begin
        cnt_q <= cnt_q - WLEN_W'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hop_q  <= hop_i;
      rtt_q  <= rtt_us_i;
      lost_q <= lost_i;
      bad_q  <= !in_range;
    end
    if (state_q == ST_UPD) begin
      new_q      <= upd_rec;
      pos_q      <= upd_rec.slot;
      n_q        <= n_wide[WLEN_W-1:0];
      sum_q      <= '0;
      loss_num_q <= DIV_N_W'((upd_rec.tot - upd_rec.rec) * DIV_N_W'(LOSS_SCALE));
    end else begin
      if (win_re) pos_q <= pos_prev;
      if (rd_pend_q) sum_q <= sum_q + SUM_W'(win_rd_q);
    end
    if (load_out) begin
      if (bad_q) begin
        min_q  <= '0;
        max_q  <= '0;
        avg_q  <= '0;
        loss_q <= '0;
        sv_q   <= 1'b0;
      end else begin
        sv_q   <= (new_q.rec != '0);
        min_q  <= (new_q.rec != '0) ? new_q.min_t : '0;
        max_q  <= (new_q.rec != '0) ? new_q.max_t : '0;
        avg_q  <= (new_q.rec != '0) ? avg_quot[RTT_W-1:0] : '0;
        loss_q <= loss_quot[LOSS_W-1:0];
      end
    end
  end

  // Record memory: read at acceptance, written back in the update cycle.
  always_ff @(posedge clk_i) begin
    if (accept) rec_rd_q <= rec_mem[HW'(hop_i)];
    if (state_q == ST_UPD) rec_mem[hop_idx] <= upd_rec;
  end

  // Window memory: one write per received time, one read per cycle while summing.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD && !lost_q) win_mem[win_waddr] <= rtt_q;
    if (win_re) win_rd_q <= win_mem[win_raddr];
  end

  // Mean of the window and loss share, computed side by side.
  phlst_div u_avg_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (DIV_N_W'(sum_q)),
    .den_i   ((n_q == '0) ? DIV_D_W'(1) : DIV_D_W'(n_q)),
    .done_o  (avg_done),
    .quot_o  (avg_quot)
  );

  phlst_div u_loss_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (loss_num_q),
    .den_i   (new_q.tot),
    .done_o  (loss_done),
    .quot_o  (loss_quot)
  );

  assign out_valid_o     = out_valid_q;
  assign min_us_o        = min_q;
  assign max_us_o        = max_q;
  assign avg_us_o        = avg_q;
  assign loss_centipct_o = loss_q;
  assign stats_valid_o   = sv_q;
endmodule
`default_nettype wire

>>> rtl/core/phlst_checker.sv
// Port-level checks for the per-hop latency statistics table.
`default_nettype none
`include "per_hop_latency_stats_table_unit_defines.svh"
module phlst_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          out_valid_o,
  input wire                          out_stall_i,
  input wire [phlst_pkg::RTT_W-1:0]   min_us_o,
  input wire [phlst_pkg::RTT_W-1:0]   max_us_o,
  input wire [phlst_pkg::RTT_W-1:0]   avg_us_o,
  input wire [phlst_pkg::LOSS_W-1:0]  loss_centipct_o,
  input wire                          stats_valid_o
);
  import phlst_pkg::*;

  // Without a reply the time fields stay zero.
  `PHLST_ASSERT_NOW(a_no_reply_zero, clk_i, rst_ni, out_valid_o && !stats_valid_o, min_us_o == '0 && max_us_o == '0 && avg_us_o == '0, "times nonzero without reply")

  // The mean lies between the extremes.
  `PHLST_ASSERT_NOW(a_avg_bounded, clk_i, rst_ni, out_valid_o && stats_valid_o, min_us_o <= avg_us_o && avg_us_o <= max_us_o, "mean outside min and max")

  // Loss never exceeds one hundred percent.
  `PHLST_ASSERT_NOW(a_loss_range, clk_i, rst_ni, out_valid_o, int'(loss_centipct_o) <= LOSS_SCALE, "loss above full scale")

  // A stalled result holds.
  `PHLST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(avg_us_o) && $stable(loss_centipct_o), "stalled result changed")
endmodule

bind per_hop_latency_stats_table_unit phlst_checker u_phlst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .min_us_o        (min_us_o),
  .max_us_o        (max_us_o),
  .avg_us_o        (avg_us_o),
  .loss_centipct_o (loss_centipct_o),
  .stats_valid_o   (stats_valid_o)
);
`default_nettype wire
